/* rtl/core/ccsoc_pkg.sv */
`default_nettype none
package ccsoc_pkg;

  // field widths
  localparam int CAP_W   = 15;
  localparam int THR_W   = 31;
  localparam int DB_W    = 15;
  localparam int PER_W   = 32;
  localparam int CUR_W   = 16;
  localparam int MODE_W  = 2;
  localparam int TIME_W  = 32;
  localparam int SOC_W   = 7;
  localparam int AH_W    = 16;
  localparam int ACC_W   = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd3;

  localparam logic [CAP_W-1:0] CAP_RST = 15'd100;
  localparam logic [THR_W-1:0] THR_RST = 31'd1800000;
  localparam logic [DB_W-1:0]  DB_RST  = 15'd3;
  localparam logic [PER_W-1:0] PER_RST = 32'd4000;

  localparam logic [MODE_W-1:0] MODE_CHARGE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISCHARGE = 2'd2;

  localparam logic [SOC_W-1:0] SOC_FULL        = 7'd100;
  localparam logic [SOC_W-1:0] SOC_RAISE_LIMIT = 7'd99;
  localparam logic [SOC_W-1:0] SOC_LOWER_LIMIT = 7'd1;

  // floor(cap/100) == (cap * DIV100_RECIP) >> DIV100_SHIFT for any 15-bit cap
  localparam int RECIP_W = 16;
  localparam logic [RECIP_W-1:0] DIV100_RECIP = 16'd41944;
  localparam int DIV100_SHIFT = 22;
  localparam int CAPQ_W = CAP_W + RECIP_W - DIV100_SHIFT;

  // SOC divide: 22-bit dividend (ah * 100), one quotient bit per step
  localparam int PROD_W    = 22;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = 5;

  // micro-ops
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
  localparam logic [OP_W-1:0] OP_WAIT  = 4'd1;
  localparam logic [OP_W-1:0] OP_ACC   = 4'd2;
  localparam logic [OP_W-1:0] OP_CARRY = 4'd3;
  localparam logic [OP_W-1:0] OP_FAULT = 4'd4;
  localparam logic [OP_W-1:0] OP_TEST  = 4'd5;
  localparam logic [OP_W-1:0] OP_CLAMP = 4'd6;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd8;
  localparam logic [OP_W-1:0] OP_SOC   = 4'd9;
  localparam logic [OP_W-1:0] OP_EMIT  = 4'd10;

  // jump conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEVER       = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS      = 3'd1;
  localparam logic [COND_W-1:0] C_NO_INPUT    = 3'd2;
  localparam logic [COND_W-1:0] C_NOT_ELAPSED = 3'd3;
  localparam logic [COND_W-1:0] C_CNT_NZ      = 3'd4;
  localparam logic [COND_W-1:0] C_OUT_BUSY    = 3'd5;

  // program steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_ACC   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CARRY = 4'd2;
  localparam logic [STEP_W-1:0] STEP_FAULT = 4'd3;
  localparam logic [STEP_W-1:0] STEP_TEST  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CLAMP = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DIV   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SOC   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd9;
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_EMIT;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic [THR_W-1:0] threshold;
    logic [DB_W-1:0]  deadband;
    logic [PER_W-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
    logic              eop;
  } uword_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ctrl_t;

  typedef struct packed {
    logic no_input;
    logic not_elapsed;
    logic cnt_nz;
    logic out_busy;
  } cond_t;

  // control store: jump to target when cond holds, else fall through
  // (or back to the wait step when eop is set)
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    begin
      case (step)
        STEP_WAIT:  w = '{OP_WAIT,  C_NO_INPUT,    STEP_WAIT, 1'b0};
        STEP_ACC:   w = '{OP_ACC,   C_NEVER,       STEP_WAIT, 1'b0};
        STEP_CARRY: w = '{OP_CARRY, C_NEVER,       STEP_WAIT, 1'b0};
        STEP_FAULT: w = '{OP_FAULT, C_NEVER,       STEP_WAIT, 1'b0};
        STEP_TEST:  w = '{OP_TEST,  C_NOT_ELAPSED, STEP_EMIT, 1'b0};
        STEP_CLAMP: w = '{OP_CLAMP, C_NEVER,       STEP_WAIT, 1'b0};
        STEP_MUL:   w = '{OP_MUL,   C_NEVER,       STEP_WAIT, 1'b0};
        STEP_DIV:   w = '{OP_DIV,   C_CNT_NZ,      STEP_DIV,  1'b0};
        STEP_SOC:   w = '{OP_SOC,   C_NEVER,       STEP_WAIT, 1'b0};
        STEP_EMIT:  w = '{OP_EMIT,  C_OUT_BUSY,    STEP_EMIT, 1'b1};
        default:    w = '{OP_NOP,   C_ALWAYS,      STEP_WAIT, 1'b0};
      endcase
      return w;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ccsoc_ifs.sv */
`default_nettype none
interface ccsoc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ccsoc_pkg::CUR_W-1:0]    current_sample;
  logic [ccsoc_pkg::MODE_W-1:0]          pack_mode;
  logic                                  over_voltage_fault;
  logic                                  under_voltage_fault;
  logic [ccsoc_pkg::TIME_W-1:0]          now_ms;

  modport source (output valid, current_sample, pack_mode, over_voltage_fault,
                  under_voltage_fault, now_ms, input ready);
  modport sink (input valid, current_sample, pack_mode, over_voltage_fault,
                under_voltage_fault, now_ms, output ready);
endinterface

interface ccsoc_out_if;
  logic                               valid;
  logic                               ready;
  logic [ccsoc_pkg::SOC_W-1:0]        soc_percent;
  logic signed [ccsoc_pkg::AH_W-1:0]  ah_count;
  logic                               soc_updated;

  modport source (output valid, soc_percent, ah_count, soc_updated, input ready);
  modport sink (input valid, soc_percent, ah_count, soc_updated, output ready);
endinterface

interface ccsoc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ccsoc_pkg::CFG_IDX_W-1:0]     index;
  logic [ccsoc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/ccsoc_cfg_regs.sv */
`default_nettype none
module ccsoc_cfg_regs (
  input  wire logic       clk,
  input  wire logic       rst_n,
  ccsoc_cfg_if.sink       cfg_ch,
  output ccsoc_pkg::cfg_t cfg
);

  ccsoc_pkg::cfg_t cfg_r;
  ccsoc_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ccsoc_pkg::REG_CAPACITY:  cfg_nxt.capacity  = cfg_ch.data[ccsoc_pkg::CAP_W-1:0];
        ccsoc_pkg::REG_THRESHOLD: cfg_nxt.threshold = cfg_ch.data[ccsoc_pkg::THR_W-1:0];
        ccsoc_pkg::REG_DEADBAND:  cfg_nxt.deadband  = cfg_ch.data[ccsoc_pkg::DB_W-1:0];
        ccsoc_pkg::REG_PERIOD:    cfg_nxt.period    = cfg_ch.data[ccsoc_pkg::PER_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity  <= ccsoc_pkg::CAP_RST;
      cfg_r.threshold <= ccsoc_pkg::THR_RST;
      cfg_r.deadband  <= ccsoc_pkg::DB_RST;
      cfg_r.period    <= ccsoc_pkg::PER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ccsoc_seq.sv */
`default_nettype none
module ccsoc_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ccsoc_pkg::cond_t cond,
  output ccsoc_pkg::ctrl_t      ctrl
);

  logic [ccsoc_pkg::STEP_W-1:0] pc_r;
  logic [ccsoc_pkg::STEP_W-1:0] pc_nxt;
  ccsoc_pkg::uword_t            uw;
  logic                         take;

  assign uw      = ccsoc_pkg::ucode(pc_r);
  assign ctrl.op = uw.op;

  always_comb begin
    case (uw.cond)
      ccsoc_pkg::C_NEVER:       take = 1'b0;
      ccsoc_pkg::C_ALWAYS:      take = 1'b1;
      ccsoc_pkg::C_NO_INPUT:    take = cond.no_input;
      ccsoc_pkg::C_NOT_ELAPSED: take = cond.not_elapsed;
      ccsoc_pkg::C_CNT_NZ:      take = cond.cnt_nz;
      ccsoc_pkg::C_OUT_BUSY:    take = cond.out_busy;
      default:                  take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_nxt = uw.target;
    end else if (uw.eop) begin
      pc_nxt = ccsoc_pkg::STEP_WAIT;
    end else begin
      pc_nxt = pc_r + ccsoc_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ccsoc_pkg::STEP_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= ccsoc_pkg::LAST_STEP)
    else $error("sequencer left the program");

  a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == ccsoc_pkg::OP_WAIT && !cond.no_input) |=> ctrl.op == ccsoc_pkg::OP_ACC)
    else $error("accepted sample did not start accumulate step");

  a_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == ccsoc_pkg::OP_EMIT && !cond.out_busy) |=> pc_r == ccsoc_pkg::STEP_WAIT)
    else $error("emit did not return to wait step");

endmodule
`default_nettype wire

/* rtl/core/ccsoc_dpath.sv */
`default_nettype none
module ccsoc_dpath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ccsoc_pkg::cfg_t  cfg,
  input  wire ccsoc_pkg::ctrl_t ctrl,
  output ccsoc_pkg::cond_t      cond,
  ccsoc_in_if.sink              in_ch,
  ccsoc_out_if.source           out_ch
);

  localparam int ACC_W  = ccsoc_pkg::ACC_W;
  localparam int AH_W   = ccsoc_pkg::AH_W;
  localparam int CAP_W  = ccsoc_pkg::CAP_W;
  localparam int PROD_W = ccsoc_pkg::PROD_W;
  localparam int SOC_W  = ccsoc_pkg::SOC_W;
  localparam int CUR_W  = ccsoc_pkg::CUR_W;

  // latched sample
  logic signed [CUR_W-1:0]            cur_r,  cur_nxt;
  logic [ccsoc_pkg::MODE_W-1:0]       mode_r, mode_nxt;
  logic                               ov_r,   ov_nxt;
  logic                               uv_r,   uv_nxt;
  logic [ccsoc_pkg::TIME_W-1:0]       now_r,  now_nxt;

  // architectural state
  logic signed [ACC_W-1:0]            acc_r,  acc_nxt;
  logic signed [AH_W-1:0]             ah_r,   ah_nxt;
  logic [SOC_W-1:0]                   soc_r,  soc_nxt;
  logic [ccsoc_pkg::TIME_W-1:0]       last_r, last_nxt;

  // work registers
  logic                               upd_r,  upd_nxt;
  logic [CAP_W-1:0]                   rem_r,  rem_nxt;
  logic [PROD_W-1:0]                  dvd_r,  dvd_nxt;
  logic [ccsoc_pkg::CNT_W-1:0]        cnt_r,  cnt_nxt;

  // result register
  logic                               out_valid_r, out_valid_nxt;
  logic [SOC_W-1:0]                   out_soc_r,   out_soc_nxt;
  logic signed [AH_W-1:0]             out_ah_r,    out_ah_nxt;
  logic                               out_upd_r,   out_upd_nxt;

  logic                               busy;
  logic [CUR_W-1:0]                   mag;
  logic                               active;
  logic [ACC_W:0]                     acc_sum;
  logic signed [ACC_W-1:0]            acc_sat;
  logic signed [ACC_W-1:0]            thr_pos;
  logic signed [ACC_W-1:0]            thr_neg;
  logic signed [AH_W-1:0]             cap_s;
  logic                               elapsed;
  logic [CAP_W+ccsoc_pkg::RECIP_W-1:0] recip_prod;
  logic [ccsoc_pkg::CAPQ_W-1:0]       cap_q;
  logic signed [AH_W-1:0]             ah_floor;
  logic [CAP_W:0]                     trial;
  logic                               qbit;

  assign busy = out_valid_r && !out_ch.ready;

  assign in_ch.ready    = (ctrl.op == ccsoc_pkg::OP_WAIT);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.soc_percent = out_soc_r;
  assign out_ch.ah_count    = out_ah_r;
  assign out_ch.soc_updated = out_upd_r;

  assign cond.no_input    = !in_ch.valid;
  assign cond.not_elapsed = !elapsed;
  assign cond.cnt_nz      = (cnt_r != '0);
  assign cond.out_busy    = busy;

  assign mag    = cur_r[CUR_W-1] ? (~cur_r + CUR_W'(1)) : cur_r;
  assign active = (mode_r == ccsoc_pkg::MODE_CHARGE || mode_r == ccsoc_pkg::MODE_DISCHARGE)
                  && (mag > {1'b0, cfg.deadband});

  assign acc_sum = {acc_r[ACC_W-1], acc_r} + {{(ACC_W+1-CUR_W){cur_r[CUR_W-1]}}, cur_r};

  // saturate to the signed 32-bit range
  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  assign thr_pos = {1'b0, cfg.threshold};
  assign thr_neg = -thr_pos;
  assign cap_s   = {1'b0, cfg.capacity};
  assign elapsed = (now_r - last_r) >= cfg.period;

  assign recip_prod = cfg.capacity * ccsoc_pkg::DIV100_RECIP;
  assign cap_q      = recip_prod[CAP_W+ccsoc_pkg::RECIP_W-1:ccsoc_pkg::DIV100_SHIFT];
  assign ah_floor   = {{(AH_W-ccsoc_pkg::CAPQ_W){1'b0}}, cap_q} + AH_W'(1);

  assign trial = {rem_r, dvd_r[PROD_W-1]};
  assign qbit  = (trial >= {1'b0, cfg.capacity});

  always_comb begin
    cur_nxt  = cur_r;
    mode_nxt = mode_r;
    ov_nxt   = ov_r;
    uv_nxt   = uv_r;
    now_nxt  = now_r;
    acc_nxt  = acc_r;
    ah_nxt   = ah_r;
    soc_nxt  = soc_r;
    last_nxt = last_r;
    upd_nxt  = upd_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    out_soc_nxt = out_soc_r;
    out_ah_nxt  = out_ah_r;
    out_upd_nxt = out_upd_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    case (ctrl.op)
      ccsoc_pkg::OP_WAIT: begin
        if (in_ch.valid) begin
          cur_nxt  = in_ch.current_sample;
          mode_nxt = in_ch.pack_mode;
          ov_nxt   = in_ch.over_voltage_fault;
          uv_nxt   = in_ch.under_voltage_fault;
          now_nxt  = in_ch.now_ms;
        end
      end
      ccsoc_pkg::OP_ACC: begin
        if (active) begin
          acc_nxt = acc_sat;
        end
      end
      ccsoc_pkg::OP_CARRY: begin
        // SOC here is still the value left by the previous sample
        if (acc_r > thr_pos) begin
          acc_nxt = acc_r - thr_pos;
          if (soc_r >= ccsoc_pkg::SOC_LOWER_LIMIT && ah_r != {1'b1, {(AH_W-1){1'b0}}}) begin
            ah_nxt = ah_r - AH_W'(1);
          end
        end else if (acc_r < thr_neg) begin
          acc_nxt = acc_r + thr_pos;
          if (soc_r < ccsoc_pkg::SOC_RAISE_LIMIT && ah_r != {1'b0, {(AH_W-1){1'b1}}}) begin
            ah_nxt = ah_r + AH_W'(1);
          end
        end
      end
      ccsoc_pkg::OP_FAULT: begin
        if (ov_r) begin
          ah_nxt  = cap_s;
          soc_nxt = ccsoc_pkg::SOC_FULL;
        end else if (uv_r && mode_r != ccsoc_pkg::MODE_CHARGE) begin
          ah_nxt  = '0;
          soc_nxt = '0;
        end
      end
      ccsoc_pkg::OP_TEST: begin
        upd_nxt = elapsed;
      end
      ccsoc_pkg::OP_CLAMP: begin
        if (ah_r > cap_s) begin
          ah_nxt = cap_s;
        end else if (ah_r <= 0) begin
          ah_nxt = uv_r ? '0 : ah_floor;
        end
      end
      ccsoc_pkg::OP_MUL: begin
        dvd_nxt = {{(PROD_W-AH_W+1){1'b0}}, ah_r[AH_W-2:0]} * PROD_W'(ccsoc_pkg::SOC_FULL);
        rem_nxt = '0;
        cnt_nxt = ccsoc_pkg::CNT_W'(ccsoc_pkg::DIV_STEPS - 1);
      end
      ccsoc_pkg::OP_DIV: begin
        // restoring divide, quotient shifts in behind the dividend
        rem_nxt = qbit ? CAP_W'(trial - {1'b0, cfg.capacity}) : trial[CAP_W-1:0];
        dvd_nxt = {dvd_r[PROD_W-2:0], qbit};
        cnt_nxt = cnt_r - ccsoc_pkg::CNT_W'(1);
      end
      ccsoc_pkg::OP_SOC: begin
        if (cfg.capacity == '0 || ah_r <= 0) begin
          soc_nxt = '0;
        end else if (dvd_r > PROD_W'(ccsoc_pkg::SOC_FULL)) begin
          soc_nxt = ccsoc_pkg::SOC_FULL;
        end else begin
          soc_nxt = dvd_r[SOC_W-1:0];
        end
        last_nxt = now_r;
      end
      ccsoc_pkg::OP_EMIT: begin
        if (!busy) begin
          out_valid_nxt = 1'b1;
          out_soc_nxt   = soc_r;
          out_ah_nxt    = ah_r;
          out_upd_nxt   = upd_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      ah_r        <= '0;
      soc_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      ah_r        <= ah_nxt;
      soc_r       <= soc_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    mode_r    <= mode_nxt;
    ov_r      <= ov_nxt;
    uv_r      <= uv_nxt;
    now_r     <= now_nxt;
    upd_r     <= upd_nxt;
    rem_r     <= rem_nxt;
    dvd_r     <= dvd_nxt;
    cnt_r     <= cnt_nxt;
    out_soc_r <= out_soc_nxt;
    out_ah_r  <= out_ah_nxt;
    out_upd_r <= out_upd_nxt;
  end

  a_soc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    soc_r <= ccsoc_pkg::SOC_FULL)
    else $error("stored SOC above full");

  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == ccsoc_pkg::OP_CLAMP && cfg.capacity != '0)
      |=> ah_r <= $signed({1'b0, $past(cfg.capacity)}))
    else $error("amp-hour count above capacity after clamp");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.op == ccsoc_pkg::OP_EMIT))
    else $error("result appeared outside emit step");

endmodule
`default_nettype wire

/* rtl/core/coulomb_counter_soc_top.sv */
`default_nettype none
// channel   dir  handshake     payload
// in_ch     in   valid/ready   current_sample, pack_mode, over/under_voltage_fault, now_ms
// out_ch    out  valid/ready   soc_percent, ah_count, soc_updated
// cfg_ch    in   valid/ready   index, data (always ready)
//
// A sample runs the accumulate, carry, fault and test steps, then emit; when the periodic
// update runs, clamp, multiply, the one-bit-per-step SOC divide and SOC steps precede emit.
// Synchronous reset loads register defaults, clears state, parks the
// sequencer at its wait step. A result waits in the output register while the
// next sample is taken; the emit step stalls only if that result is still held.
module coulomb_counter_soc_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ccsoc_in_if.sink    in_ch,
  ccsoc_out_if.source out_ch,
  ccsoc_cfg_if.sink   cfg_ch
);

  ccsoc_pkg::cfg_t  cfg;
  ccsoc_pkg::ctrl_t ctrl;
  ccsoc_pkg::cond_t cond;

  ccsoc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ccsoc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctrl  (ctrl)
  );

  ccsoc_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .ctrl   (ctrl),
    .cond   (cond),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
